// ===== design/assert_macros.svh =====
// Assertion macros shared by the ordered-list RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/olms_pkg.sv =====
// Shared constants, command codes and link memory port type for the ordered list.
// No dependencies.
`timescale 1ns / 1ps

package olms_pkg;

    // Box capacity and link memory geometry (two sentinels around the boxes)
    localparam int MAX_BOXES  = 1024;
    localparam int LINK_DEPTH = MAX_BOXES + 2;
    localparam int IDX_W      = $clog2(LINK_DEPTH);

    // Fixed field widths
    localparam int CMD_W = 3;
    localparam int BOX_W = 11;
    localparam int SUM_W = 19;

    // Width wide enough to compare box fields against the box count
    localparam int CMP_W = (IDX_W > BOX_W) ? IDX_W : BOX_W;

    // Reset value of the box count register, limited to its field width
    localparam int ITEM_COUNT_RST = (MAX_BOXES > 2047) ? 2047 : MAX_BOXES;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE_A = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REV    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUM    = 3'd5;

    // One port request to a link memory: one write and one read per cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } link_req_t;

endpackage

// ===== design/ordered_list_move_swap_reverse_top.sv =====
// Top level of the ordered list: sequencer plus next-link and prev-link memories.
// Depends on olms_pkg, olms_ctrl and olms_link_ram.
`timescale 1ns / 1ps

// Keeps boxes 1..count in an order held as a doubly linked list in two synchronous
// RAMs (next and prev links, one write and one read port each, sentinels at both
// ends). One request is in work at a time; a finished result waits in the output
// register while the next request is taken. A move or a swap reads the links of x,
// then those of y, then does three write steps, or four for a swap of boxes apart,
// each step one write per write port; reverse and a rejected request go straight
// to the result, sum walks the list (one link read per cycle) and init rebuilds it
// (one entry rebuilt per cycle). After reset the block rebuilds the list and holds
// in_stall high meanwhile; item_count writes are taken at any time and take effect
// at the next init.
module ordered_list_move_swap_reverse_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [olms_pkg::CMD_W-1:0]     command,
    input  logic [olms_pkg::BOX_W-1:0]     first_box,
    input  logic [olms_pkg::BOX_W-1:0]     second_box,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [olms_pkg::SUM_W-1:0]     odd_position_sum,
    output logic                           error,
    input  logic                           cfg_wr_en,
    input  logic [olms_pkg::BOX_W-1:0]     cfg_wr_data
);

    olms_pkg::link_req_t               nxt_req;
    olms_pkg::link_req_t               prv_req;
    logic [olms_pkg::IDX_W-1:0]        nxt_rdata;
    logic [olms_pkg::IDX_W-1:0]        prv_rdata;

    // Sequencer
    olms_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .first_box        (first_box),
        .second_box       (second_box),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .odd_position_sum (odd_position_sum),
        .error            (error),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .nxt_req          (nxt_req),
        .prv_req          (prv_req),
        .nxt_rdata        (nxt_rdata),
        .prv_rdata        (prv_rdata)
    );

    // Next-link memory
    olms_link_ram #(
        .DEPTH (olms_pkg::LINK_DEPTH),
        .WIDTH (olms_pkg::IDX_W)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_req.we),
        .waddr (nxt_req.waddr),
        .wdata (nxt_req.wdata),
        .raddr (nxt_req.raddr),
        .rdata (nxt_rdata)
    );

    // Prev-link memory
    olms_link_ram #(
        .DEPTH (olms_pkg::LINK_DEPTH),
        .WIDTH (olms_pkg::IDX_W)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prv_req.we),
        .waddr (prv_req.waddr),
        .wdata (prv_req.wdata),
        .raddr (prv_req.raddr),
        .rdata (prv_rdata)
    );

endmodule

// ===== design/olms_link_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents on a same-address write. No package dependency.
`timescale 1ns / 1ps

module olms_link_ram #(
    parameter int DEPTH = 1026,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== design/olms_ctrl.sv =====
// Command sequencer for the ordered list: checks requests, reads links, writes them
// back, walks the list for sums and rebuilds it. Uses olms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module olms_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [olms_pkg::CMD_W-1:0]     command,
    input  logic [olms_pkg::BOX_W-1:0]     first_box,
    input  logic [olms_pkg::BOX_W-1:0]     second_box,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [olms_pkg::SUM_W-1:0]     odd_position_sum,
    output logic                           error,
    // box count register
    input  logic                           cfg_wr_en,
    input  logic [olms_pkg::BOX_W-1:0]     cfg_wr_data,
    // link memories
    output olms_pkg::link_req_t            nxt_req,
    output olms_pkg::link_req_t            prv_req,
    input  logic [olms_pkg::IDX_W-1:0]     nxt_rdata,
    input  logic [olms_pkg::IDX_W-1:0]     prv_rdata
);

    localparam int IW = olms_pkg::IDX_W;
    localparam int SW = olms_pkg::SUM_W;
    localparam int CW = olms_pkg::CMP_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_RDY   = 3'd2;
    localparam logic [2:0] S_CAP   = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Saturate the register value to 1..MAX_BOXES
    function automatic logic [IW-1:0] clamp_count(input logic [olms_pkg::BOX_W-1:0] v);
        logic [CW-1:0] vw;
        logic [IW-1:0] res;
        vw = CW'(v);
        if (vw == '0)
        begin
            res = IW'(1);
        end
        else if (vw > CW'(olms_pkg::MAX_BOXES))
        begin
            res = IW'(olms_pkg::MAX_BOXES);
        end
        else
        begin
            res = IW'(vw);
        end
        return res;
    endfunction

    logic [2:0]                    state_reg,       state_next;
    logic [olms_pkg::BOX_W-1:0]    item_count_reg;
    logic [olms_pkg::CMD_W-1:0]    cmd_reg,         cmd_next;
    logic [IW-1:0]                 x_reg,           x_next;
    logic [IW-1:0]                 y_reg,           y_next;
    logic [IW-1:0]                 count_reg,       count_next;
    logic                          reversed_reg,    reversed_next;
    logic [IW-1:0]                 sweep_cnt_reg,   sweep_cnt_next;
    logic                          sweep_reply_reg, sweep_reply_next;
    logic [1:0]                    step_reg,        step_next;
    logic [IW-1:0]                 px_reg,          px_next;
    logic [IW-1:0]                 nx_reg,          nx_next;
    logic [IW-1:0]                 py_reg,          py_next;
    logic [IW-1:0]                 ny_reg,          ny_next;
    logic [IW-1:0]                 walk_cnt_reg,    walk_cnt_next;
    logic [SW-1:0]                 sum_reg,         sum_next;
    logic                          err_reg,         err_next;
    logic                          out_valid_reg,   out_valid_next;
    logic [SW-1:0]                 out_sum_reg,     out_sum_next;
    logic                          out_err_reg,     out_err_next;

    logic [IW-1:0] cnt_p1;
    logic [CW-1:0] xw;
    logic [CW-1:0] yw;
    logic [CW-1:0] cw;
    logic          bad_boxes;
    logic [IW-1:0] walk_idx;

    // Write plan for edit commands
    logic          is_swap;
    logic          place_before;
    logic          adj_xy;
    logic          adj_yx;
    logic [IW-1:0] py_adj;
    logic [IW-1:0] ny_adj;
    logic [1:0]    last_step;
    logic [IW-1:0] wn_addr;
    logic [IW-1:0] wn_data;
    logic [IW-1:0] wp_addr;
    logic [IW-1:0] wp_data;

    assign cnt_p1 = count_reg + IW'(1);

    // Range and equality check of the two boxes
    assign xw        = CW'(first_box);
    assign yw        = CW'(second_box);
    assign cw        = CW'(count_reg);
    assign bad_boxes = (xw == yw) || (xw == '0) || (xw > cw) || (yw == '0) || (yw > cw);

    // Next entry of the walk in the current direction
    assign walk_idx = reversed_reg ? prv_rdata : nxt_rdata;

    // Edit classification; the adjusted neighbors account for the unlink of x
    assign is_swap      = (cmd_reg == olms_pkg::CMD_SWAP);
    assign place_before = (cmd_reg == olms_pkg::CMD_MOVE_B) != reversed_reg;
    assign adj_xy       = (py_reg == x_reg);
    assign adj_yx       = (px_reg == y_reg);
    assign py_adj       = adj_xy ? px_reg : py_reg;
    assign ny_adj       = (ny_reg == x_reg) ? nx_reg : ny_reg;
    assign last_step    = (is_swap && !adj_xy && !adj_yx) ? 2'd3 : 2'd2;

    // One next-link write and one prev-link write per step, in list order
    always_comb
    begin
        wn_addr = x_reg;
        wn_data = y_reg;
        wp_addr = x_reg;
        wp_data = y_reg;
        if (is_swap && adj_xy)
        begin
            // x directly before y
            unique case (step_reg)
                2'd0:
                begin
                    wn_addr = x_reg;  wn_data = ny_reg;
                    wp_addr = x_reg;  wp_data = y_reg;
                end
                2'd1:
                begin
                    wn_addr = y_reg;  wn_data = x_reg;
                    wp_addr = y_reg;  wp_data = px_reg;
                end
                default:
                begin
                    wn_addr = px_reg; wn_data = y_reg;
                    wp_addr = ny_reg; wp_data = x_reg;
                end
            endcase
        end
        else if (is_swap && adj_yx)
        begin
            // y directly before x
            unique case (step_reg)
                2'd0:
                begin
                    wn_addr = y_reg;  wn_data = nx_reg;
                    wp_addr = y_reg;  wp_data = x_reg;
                end
                2'd1:
                begin
                    wn_addr = x_reg;  wn_data = y_reg;
                    wp_addr = x_reg;  wp_data = py_reg;
                end
                default:
                begin
                    wn_addr = py_reg; wn_data = x_reg;
                    wp_addr = nx_reg; wp_data = y_reg;
                end
            endcase
        end
        else if (is_swap)
        begin
            // boxes apart from each other
            unique case (step_reg)
                2'd0:
                begin
                    wn_addr = y_reg;  wn_data = nx_reg;
                    wp_addr = y_reg;  wp_data = px_reg;
                end
                2'd1:
                begin
                    wn_addr = x_reg;  wn_data = ny_reg;
                    wp_addr = x_reg;  wp_data = py_reg;
                end
                2'd2:
                begin
                    wn_addr = px_reg; wn_data = y_reg;
                    wp_addr = ny_reg; wp_data = x_reg;
                end
                default:
                begin
                    wn_addr = py_reg; wn_data = x_reg;
                    wp_addr = nx_reg; wp_data = y_reg;
                end
            endcase
        end
        else if (place_before)
        begin
            unique case (step_reg)
                2'd0:
                begin
                    wn_addr = px_reg; wn_data = nx_reg;
                    wp_addr = nx_reg; wp_data = px_reg;
                end
                2'd1:
                begin
                    wn_addr = x_reg;  wn_data = y_reg;
                    wp_addr = x_reg;  wp_data = py_adj;
                end
                default:
                begin
                    wn_addr = py_adj; wn_data = x_reg;
                    wp_addr = y_reg;  wp_data = x_reg;
                end
            endcase
        end
        else
        begin
            unique case (step_reg)
                2'd0:
                begin
                    wn_addr = px_reg; wn_data = nx_reg;
                    wp_addr = nx_reg; wp_data = px_reg;
                end
                2'd1:
                begin
                    wn_addr = x_reg;  wn_data = ny_adj;
                    wp_addr = x_reg;  wp_data = y_reg;
                end
                default:
                begin
                    wn_addr = y_reg;  wn_data = x_reg;
                    wp_addr = ny_adj; wp_data = x_reg;
                end
            endcase
        end
    end

    // Sequencer next state and memory requests
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        count_next       = count_reg;
        reversed_next    = reversed_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        sweep_reply_next = sweep_reply_reg;
        step_next        = step_reg;
        px_next          = px_reg;
        nx_next          = nx_reg;
        py_next          = py_reg;
        ny_next          = ny_reg;
        walk_cnt_next    = walk_cnt_reg;
        sum_next         = sum_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg;
        out_sum_next     = out_sum_reg;
        out_err_next     = out_err_reg;

        nxt_req       = '0;
        prv_req       = '0;
        nxt_req.raddr = x_reg;
        prv_req.raddr = x_reg;

        // Result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // Start reads for x, or the walk start for a sum
                if (command == olms_pkg::CMD_SUM)
                begin
                    nxt_req.raddr = '0;
                    prv_req.raddr = cnt_p1;
                end
                else
                begin
                    nxt_req.raddr = IW'(first_box);
                    prv_req.raddr = IW'(first_box);
                end
                if (in_valid)
                begin
                    cmd_next = command;
                    x_next   = IW'(first_box);
                    y_next   = IW'(second_box);
                    err_next = 1'b0;
                    sum_next = '0;
                    unique case (command)
                        olms_pkg::CMD_INIT:
                        begin
                            count_next       = clamp_count(item_count_reg);
                            sweep_cnt_next   = '0;
                            sweep_reply_next = 1'b1;
                            state_next       = S_SWEEP;
                        end
                        olms_pkg::CMD_MOVE_B, olms_pkg::CMD_MOVE_A, olms_pkg::CMD_SWAP:
                        begin
                            if (bad_boxes)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDY;
                            end
                        end
                        olms_pkg::CMD_REV:
                        begin
                            reversed_next = !reversed_reg;
                            state_next    = S_DONE;
                        end
                        olms_pkg::CMD_SUM:
                        begin
                            walk_cnt_next = IW'(1);
                            state_next    = S_SUM;
                        end
                        default:
                        begin
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SWEEP:
            begin
                // Rebuild the identity chain one entry per cycle
                nxt_req.we    = 1'b1;
                nxt_req.waddr = sweep_cnt_reg;
                nxt_req.wdata = (sweep_cnt_reg == cnt_p1) ? sweep_cnt_reg
                                                          : sweep_cnt_reg + IW'(1);
                prv_req.we    = 1'b1;
                prv_req.waddr = sweep_cnt_reg;
                prv_req.wdata = (sweep_cnt_reg == '0) ? '0 : sweep_cnt_reg - IW'(1);
                if (sweep_cnt_reg == cnt_p1)
                begin
                    reversed_next    = 1'b0;
                    sweep_reply_next = 1'b0;
                    state_next       = sweep_reply_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + IW'(1);
                end
            end

            S_RDY:
            begin
                // Links of x arrive; read links of y
                px_next       = prv_rdata;
                nx_next       = nxt_rdata;
                nxt_req.raddr = y_reg;
                prv_req.raddr = y_reg;
                state_next    = S_CAP;
            end

            S_CAP:
            begin
                py_next    = prv_rdata;
                ny_next    = nxt_rdata;
                step_next  = '0;
                state_next = S_WR;
            end

            S_WR:
            begin
                nxt_req.we    = 1'b1;
                nxt_req.waddr = wn_addr;
                nxt_req.wdata = wn_data;
                prv_req.we    = 1'b1;
                prv_req.waddr = wp_addr;
                prv_req.wdata = wp_data;
                if (step_reg == last_step)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end

            S_SUM:
            begin
                // One link per cycle; odd positions add their label
                nxt_req.raddr = walk_idx;
                prv_req.raddr = walk_idx;
                if (walk_cnt_reg[0])
                begin
                    sum_next = sum_reg + SW'(walk_idx);
                end
                if (walk_cnt_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg + IW'(1);
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = sum_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            item_count_reg  <= olms_pkg::BOX_W'(olms_pkg::ITEM_COUNT_RST);
            count_reg       <= IW'(olms_pkg::MAX_BOXES);
            reversed_reg    <= 1'b0;
            sweep_cnt_reg   <= '0;
            sweep_reply_reg <= 1'b0;
            step_reg        <= '0;
            walk_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            reversed_reg    <= reversed_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            sweep_reply_reg <= sweep_reply_next;
            step_reg        <= step_next;
            walk_cnt_reg    <= walk_cnt_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                item_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        px_reg      <= px_next;
        nx_reg      <= nx_next;
        py_reg      <= py_next;
        ny_reg      <= ny_next;
        sum_reg     <= sum_next;
        err_reg     <= err_next;
        out_sum_reg <= out_sum_next;
        out_err_reg <= out_err_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign odd_position_sum = out_sum_reg;
    assign error            = out_err_reg;

    // Checks
    `ASSERT_NEVER(a_wr_state, (nxt_req.we || prv_req.we) && !(state_reg == S_SWEEP || state_reg == S_WR), "link write outside sweep or edit")
    `ASSERT_CLK(a_wr_range, (nxt_req.we || prv_req.we) |-> (nxt_req.waddr <= cnt_p1) && (prv_req.waddr <= cnt_p1), "link write beyond tail sentinel")
    `ASSERT_CLK(a_walk_bound, (state_reg == S_SUM) |-> (walk_cnt_reg != '0) && (walk_cnt_reg <= count_reg), "sum walk position out of range")
    `ASSERT_CLK(a_err_no_sum, (out_valid_reg && out_err_reg) |-> (out_sum_reg == '0), "rejected request carries a sum")

endmodule
